[sv/ftf_pkg.sv]
// Shared types, sizes and the fixed coefficient table of the trend filter.
// No dependencies; ftf_mac and the filter core import this package.
package ftf_pkg;

    localparam int TAPS           = 39;
    localparam int SAMPLE_WIDTH   = 24;
    localparam int COEF_FRAC_BITS = 20;

    localparam int COEF_W = COEF_FRAC_BITS;
    localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int TAP_W  = $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS + 1);

    localparam longint unsigned DEC_SCALE = 64'd10000000000;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]       coef_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [ACC_W-1:0]        acc_t;
    typedef logic        [TAP_W-1:0]        tap_idx_t;
    typedef logic        [CNT_W-1:0]        count_t;
    typedef logic signed [1:0]              trend_t;
    typedef logic        [TAPS-1:0][COEF_W-1:0] coef_tab_t;

    localparam trend_t TREND_FLAT = 2'sd0;
    localparam trend_t TREND_UP   = 2'sd1;
    localparam trend_t TREND_DOWN = -2'sd1;

    typedef struct packed {
        logic     start;
        logic     issue;
        logic     last;
        tap_idx_t idx;
    } mac_ctrl_t;

    // coefficients times 1e10, newest tap first
    function automatic longint coef_dec(input int k);
        longint c;
        unique case (k)
            0:  c = 64'sd4360409450;
            1:  c = 64'sd3658689069;
            2:  c = 64'sd2460452079;
            3:  c = 64'sd1104506886;
            4:  c = -64'sd54034585;
            5:  c = -64'sd760367731;
            6:  c = -64'sd933058722;
            7:  c = -64'sd670110374;
            8:  c = -64'sd190795053;
            9:  c = 64'sd259609206;
            10: c = 64'sd502044896;
            11: c = 64'sd477818607;
            12: c = 64'sd249252327;
            13: c = -64'sd47706151;
            14: c = -64'sd272432537;
            15: c = -64'sd338917071;
            16: c = -64'sd244141482;
            17: c = -64'sd55774838;
            18: c = 64'sd128149838;
            19: c = 64'sd226522218;
            20: c = 64'sd208778257;
            21: c = 64'sd100299086;
            22: c = -64'sd36771622;
            23: c = -64'sd136744850;
            24: c = -64'sd160483392;
            25: c = -64'sd108597376;
            26: c = -64'sd16060704;
            27: c = 64'sd69480557;
            28: c = 64'sd110573605;
            29: c = 64'sd95711419;
            30: c = 64'sd40444064;
            31: c = -64'sd23824623;
            32: c = -64'sd67093714;
            33: c = -64'sd72003400;
            34: c = -64'sd47717710;
            35: c = 64'sd5541115;
            36: c = 64'sd7860160;
            37: c = 64'sd130129076;
            38: c = 64'sd40364019;
            default: c = 64'sd0;
        endcase
        return c;
    endfunction

    // round each coefficient to nearest in Q0.COEF_FRAC_BITS
    function automatic coef_tab_t build_coef_tab();
        coef_tab_t       tab;
        longint          c;
        longint unsigned mag;
        longint unsigned q;
        for (int k = 0; k < TAPS; k++) begin
            c   = coef_dec(k);
            mag = (c < 0) ? longint'(-c) : longint'(c);
            q   = ((mag << COEF_FRAC_BITS) + DEC_SCALE / 2) / DEC_SCALE;
            tab[k] = (c < 0) ? COEF_W'(-q) : COEF_W'(q);
        end
        return tab;
    endfunction

    localparam coef_tab_t COEF_TAB = build_coef_tab();

endpackage

[sv/ftf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ftf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/ftf_mac.sv]
// Shared multiply-accumulate unit with round-to-nearest and saturation.
// Depends on ftf_pkg for sizes, the control struct and the coefficient table.
module ftf_mac (
    input  logic               aclk,
    input  logic               aresetn,
    input  ftf_pkg::mac_ctrl_t ctrl,
    input  ftf_pkg::sample_t   tap_data,
    output logic               y_valid,
    output ftf_pkg::sample_t   y
);
    import ftf_pkg::*;

    localparam int R_W = ACC_W + 1 - COEF_FRAC_BITS;

    localparam logic [ACC_W:0] HALF =
        {{(ACC_W + 1 - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
    localparam logic [R_W-1:0] SMAX_MAG =
        {{(R_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic [R_W-1:0] SMIN_MAG =
        {{(R_W - SAMPLE_WIDTH){1'b0}}, 1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
    localparam sample_t SMAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam sample_t SMIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    coef_t          coef_reg;
    logic           v1_reg;
    logic           last1_reg;
    prod_t          prod_reg;
    logic           v2_reg;
    logic           last2_reg;
    acc_t           acc_reg;
    logic           l3_reg;
    logic [R_W-1:0] r_reg;
    logic           neg_reg;
    logic           rv_reg;
    sample_t        y_reg;
    logic           yv_reg;

    logic [ACC_W-1:0] mag;
    logic [ACC_W:0]   rsum;
    logic [R_W-1:0]   r_next;
    sample_t          y_next;

    always_comb begin
        mag    = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        rsum   = {1'b0, mag} + HALF;
        r_next = rsum[ACC_W:COEF_FRAC_BITS];
    end

    always_comb begin
        if (neg_reg) begin
            y_next = (r_reg > SMIN_MAG) ? SMIN : -sample_t'(r_reg[SAMPLE_WIDTH-1:0]);
        end else begin
            y_next = (r_reg > SMAX_MAG) ? SMAX : sample_t'(r_reg[SAMPLE_WIDTH-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
            l3_reg    <= 1'b0;
            rv_reg    <= 1'b0;
            yv_reg    <= 1'b0;
        end else begin
            v1_reg    <= ctrl.issue;
            last1_reg <= ctrl.issue && ctrl.last;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            l3_reg    <= v2_reg && last2_reg;
            rv_reg    <= l3_reg;
            yv_reg    <= rv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.issue) begin
            coef_reg <= coef_t'(COEF_TAB[ctrl.idx]);
        end
        if (v1_reg) begin
            prod_reg <= tap_data * coef_reg;
        end
        if (ctrl.start) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + acc_t'(prod_reg);
        end
        if (l3_reg) begin
            r_reg   <= r_next;
            neg_reg <= acc_reg[ACC_W-1];
        end
        if (rv_reg) begin
            y_reg <= y_next;
        end
    end

    assign y_valid = yv_reg;
    assign y       = y_reg;

endmodule

[sv/fixed_fir_trend_filter.sv]
// Flow: a warm-up word goes through a pending register into the output register; a full
//   filter word is read from the delay line one tap a cycle, newest first, through the single
//   read port into the one shared multiplier, then waits in the pending register as well.
//   No new word is taken until the last one has been loaded into the output register.
// Reset (aresetn low, synchronous): sample count, trend and previous result go to zero,
//   the handshake goes idle; the delay line needs no clearing.
module fixed_fir_trend_filter_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ftf_pkg::sample_t s_sample,
    output logic             m_valid,
    input  logic             m_ready,
    output ftf_pkg::sample_t m_filtered,
    output ftf_pkg::trend_t  m_trend,
    output logic             m_warm
);
    import ftf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam tap_idx_t LAST_TAP = tap_idx_t'(TAPS - 1);
    localparam count_t   FULL     = count_t'(TAPS);

    logic [1:0] state_reg, state_next;
    tap_idx_t   head_reg, head_next;
    tap_idx_t   rd_addr_reg, rd_addr_next;
    tap_idx_t   idx_reg, idx_next;
    count_t     count_reg, count_next;
    sample_t    last_reg, last_next;
    trend_t     trend_reg, trend_next;
    sample_t    pend_reg, pend_next;
    logic       pend_warm_reg, pend_warm_next;
    logic       m_valid_reg, m_valid_next;
    sample_t    m_filtered_reg;
    trend_t     m_trend_reg;
    logic       m_warm_reg;

    logic      accept;
    logic      out_load;
    count_t    count_inc;
    mac_ctrl_t mac_ctrl;
    sample_t   tap_data;
    logic      y_valid;
    sample_t   y;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    assign count_inc = (count_reg < FULL) ? count_reg + 1'b1 : count_reg;

    always_comb begin
        mac_ctrl.start = accept;
        mac_ctrl.issue = (state_reg == S_READ);
        mac_ctrl.last  = (idx_reg == LAST_TAP);
        mac_ctrl.idx   = idx_reg;
    end

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        rd_addr_next   = rd_addr_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        trend_next     = trend_reg;
        pend_next      = pend_reg;
        pend_warm_next = pend_warm_reg;
        m_valid_next   = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    count_next   = count_inc;
                    head_next    = (head_reg == LAST_TAP) ? '0 : head_reg + 1'b1;
                    rd_addr_next = head_reg;
                    idx_next     = '0;
                    if (count_inc == FULL) begin
                        state_next = S_READ;
                    end else begin
                        pend_next      = s_sample;
                        pend_warm_next = 1'b0;
                        state_next     = S_OUT;
                    end
                end
            end
            S_READ: begin
                rd_addr_next = (rd_addr_reg == '0) ? LAST_TAP : rd_addr_reg - 1'b1;
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == LAST_TAP) begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                if (y_valid) begin
                    priority if (y > last_reg) begin
                        trend_next = TREND_UP;
                    end else if (y < last_reg) begin
                        trend_next = TREND_DOWN;
                    end else begin
                        trend_next = TREND_FLAT;
                    end
                    last_next      = y;
                    pend_next      = y;
                    pend_warm_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            last_reg    <= '0;
            trend_reg   <= TREND_FLAT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            trend_reg   <= trend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg   <= rd_addr_next;
        idx_reg       <= idx_next;
        pend_reg      <= pend_next;
        pend_warm_reg <= pend_warm_next;
        if (out_load) begin
            m_filtered_reg <= pend_reg;
            m_trend_reg    <= trend_reg;
            m_warm_reg     <= pend_warm_reg;
        end
    end

    ftf_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (TAPS)
    ) u_delay_line (
        .aclk  (aclk),
        .we    (accept),
        .waddr (head_reg),
        .wdata (s_sample),
        .re    (mac_ctrl.issue),
        .raddr (rd_addr_reg),
        .rdata (tap_data)
    );

    ftf_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .tap_data (tap_data),
        .y_valid  (y_valid),
        .y        (y)
    );

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;
    assign m_trend    = m_trend_reg;
    assign m_warm     = m_warm_reg;

    a_result_only_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        y_valid |-> (state_reg == S_WAIT))
        else $error("filter result arrived outside the wait state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input ready right after a word was taken");

    a_warm_needs_full_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_warm) |-> (count_reg == FULL))
        else $error("full filter word shown before the delay line was filled");

endmodule
